// ===== rtl/loop_trip_estimate_histogram_assert.svh =====
// assertion macros used by the checker file
`ifndef LOOP_TRIP_ESTIMATE_HISTOGRAM_ASSERT_SVH
`define LOOP_TRIP_ESTIMATE_HISTOGRAM_ASSERT_SVH

// property must hold at every clock edge out of reset
`define LTEH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// boolean condition that must never be seen out of reset
`define LTEH_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/lteh_pkg.sv =====
package lteh_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned USED_W        = SLOT_W + 1;
  localparam int unsigned NUM_GROUPS    = 7;
  localparam int unsigned GROUP_W       = 3;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned TRIP_W        = 32;
  localparam int unsigned HALF_W        = TRIP_W / 2;
  localparam int unsigned CLASS_W       = 8;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  // stream widths
  localparam int unsigned S_TDATA_W = 152;
  localparam int unsigned M_TDATA_W = 120;

  typedef logic [GROUP_W-1:0] group_t;

  // accuracy groups
  localparam group_t GRP_SQRT   = 3'd0;
  localparam group_t GRP_HALF   = 3'd1;
  localparam group_t GRP_MINUS2 = 3'd2;
  localparam group_t GRP_MINUS1 = 3'd3;
  localparam group_t GRP_DOUBLE = 3'd4;
  localparam group_t GRP_SQUARE = 3'd5;
  localparam group_t GRP_BEYOND = 3'd6;

  // item kinds
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef logic [NUM_GROUPS-1:0][COUNT_BITS-1:0] count_row_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [KEY_W-1:0]   key;
  } key_entry_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               is_read;
    logic [SLOT_W-1:0]  slot;
    group_t             group;
    logic [KEY_W-1:0]   key;
    logic [CLASS_W-1:0] cls;
    logic               is_new;
    logic               full;
    logic               valid;
  } work_t;

  // result beat, last field in the low bits
  typedef struct packed {
    logic                  valid;
    logic                  full;
    logic                  is_new;
    logic [CLASS_W-1:0]    cls;
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
    group_t                group;
    logic [SLOT_W-1:0]     slot;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== rtl/lteh_queue.sv =====
module lteh_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lteh_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lteh_pkg::work_t head_o
);

  lteh_pkg::work_t                    slot_q [lteh_pkg::QUEUE_DEPTH];
  logic [lteh_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [lteh_pkg::QPTR_W:0]          cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == (lteh_pkg::QPTR_W + 1)'(lteh_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/lteh_front.sv =====
module lteh_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_mode_i,
  input  logic [lteh_pkg::KEY_W-1:0]          in_key_i,
  input  logic [lteh_pkg::TRIP_W-1:0]         in_trip_i,
  input  logic [lteh_pkg::TRIP_W-1:0]         in_est_i,
  input  logic [lteh_pkg::CLASS_W-1:0]        in_class_i,
  input  logic [lteh_pkg::SLOT_W-1:0]         in_rslot_i,
  input  lteh_pkg::group_t                    in_rgroup_i,
  output logic                                push_o,
  output lteh_pkg::work_t                     push_data_o,
  input  logic                                q_full_i
);

  // capture stage
  logic                               busy_q;
  logic                               mode_q;
  logic [lteh_pkg::KEY_W-1:0]         key_q;
  logic [lteh_pkg::TRIP_W-1:0]        trip_q, est_q;
  logic [lteh_pkg::CLASS_W-1:0]       cls_q;
  logic [lteh_pkg::SLOT_W-1:0]        rslot_q;
  lteh_pkg::group_t                   rgroup_q;
  logic [lteh_pkg::TABLE_ENTRIES-1:0] hit_q, hit_d;
  logic [lteh_pkg::TRIP_W-1:0]        ee_q, ee_d, tt_q, tt_d;
  logic                               e_small_q, e_small_d, t_small_q, t_small_d;

  // key table and allocation state
  logic [lteh_pkg::KEY_W-1:0]         cam_q [lteh_pkg::TABLE_ENTRIES];
  logic [lteh_pkg::TABLE_ENTRIES-1:0] used_q;
  logic [lteh_pkg::USED_W-1:0]        slots_used_q;

  logic                               accept;
  logic                               hit;
  logic [lteh_pkg::SLOT_W-1:0]        hit_slot;
  logic                               can_alloc;
  logic                               do_alloc;
  lteh_pkg::group_t                   group;
  logic                               c_minus1, c_sqrt, c_half, c_minus2, c_double, c_square;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign push_o     = busy_q && !q_full_i;

  // parallel key compare and the two narrow squares
  always_comb begin
    for (int unsigned i = 0; i < lteh_pkg::TABLE_ENTRIES; i++) begin
      hit_d[i] = used_q[i] && (cam_q[i] == in_key_i);
    end
    ee_d      = lteh_pkg::TRIP_W'(in_est_i[lteh_pkg::HALF_W-1:0]) *
                lteh_pkg::TRIP_W'(in_est_i[lteh_pkg::HALF_W-1:0]);
    tt_d      = lteh_pkg::TRIP_W'(in_trip_i[lteh_pkg::HALF_W-1:0]) *
                lteh_pkg::TRIP_W'(in_trip_i[lteh_pkg::HALF_W-1:0]);
    e_small_d = (in_est_i[lteh_pkg::TRIP_W-1:lteh_pkg::HALF_W] == '0);
    t_small_d = (in_trip_i[lteh_pkg::TRIP_W-1:lteh_pkg::HALF_W] == '0);
  end

  // stored keys are unique, so at most one hit bit is set
  always_comb begin
    hit_slot = '0;
    for (int unsigned i = 0; i < lteh_pkg::TABLE_ENTRIES; i++) begin
      if (hit_q[i]) begin
        hit_slot = hit_slot | lteh_pkg::SLOT_W'(i);
      end
    end
  end

  assign hit       = |hit_q;
  assign can_alloc = (slots_used_q < lteh_pkg::USED_W'(lteh_pkg::TABLE_ENTRIES));
  assign do_alloc  = push_o && (mode_q == lteh_pkg::MODE_RECORD) && !hit && can_alloc;

  // estimate accuracy, tested in priority order
  always_comb begin
    c_minus1 = (trip_q != '0) && (est_q == trip_q - 1'b1);
    c_sqrt   = e_small_q && (ee_q <= trip_q);
    c_half   = (est_q <= (trip_q >> 1));
    c_minus2 = (trip_q >= lteh_pkg::TRIP_W'(2)) && (est_q <= trip_q - lteh_pkg::TRIP_W'(2));
    c_double = ({1'b0, est_q} <= {trip_q, 1'b0});
    c_square = !t_small_q || (est_q <= tt_q);
    if (c_minus1) begin
      group = lteh_pkg::GRP_MINUS1;
    end else if (c_sqrt) begin
      group = lteh_pkg::GRP_SQRT;
    end else if (c_half) begin
      group = lteh_pkg::GRP_HALF;
    end else if (c_minus2) begin
      group = lteh_pkg::GRP_MINUS2;
    end else if (c_double) begin
      group = lteh_pkg::GRP_DOUBLE;
    end else if (c_square) begin
      group = lteh_pkg::GRP_SQUARE;
    end else begin
      group = lteh_pkg::GRP_BEYOND;
    end
  end

  always_comb begin
    push_data_o         = '0;
    push_data_o.key     = key_q;
    push_data_o.cls     = cls_q;
    if (mode_q == lteh_pkg::MODE_READ) begin
      push_data_o.is_read = 1'b1;
      push_data_o.slot    = rslot_q;
      push_data_o.group   = rgroup_q;
      push_data_o.valid   = used_q[rslot_q];
    end else begin
      push_data_o.group = group;
      if (hit) begin
        push_data_o.slot  = hit_slot;
        push_data_o.valid = 1'b1;
      end else if (can_alloc) begin
        push_data_o.slot   = slots_used_q[lteh_pkg::SLOT_W-1:0];
        push_data_o.is_new = 1'b1;
        push_data_o.valid  = 1'b1;
      end else begin
        push_data_o.full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      used_q       <= '0;
      slots_used_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (push_o) begin
        busy_q <= 1'b0;
      end
      if (do_alloc) begin
        used_q[slots_used_q[lteh_pkg::SLOT_W-1:0]] <= 1'b1;
        slots_used_q <= slots_used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= in_mode_i;
      key_q     <= in_key_i;
      trip_q    <= in_trip_i;
      est_q     <= in_est_i;
      cls_q     <= in_class_i;
      rslot_q   <= in_rslot_i;
      rgroup_q  <= in_rgroup_i;
      hit_q     <= hit_d;
      ee_q      <= ee_d;
      tt_q      <= tt_d;
      e_small_q <= e_small_d;
      t_small_q <= t_small_d;
    end
    if (do_alloc) begin
      cam_q[slots_used_q[lteh_pkg::SLOT_W-1:0]] <= key_q;
    end
  end

endmodule

// ===== rtl/lteh_back.sv =====
module lteh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  lteh_pkg::work_t   q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lteh_pkg::result_t out_data_o
);

  lteh_pkg::key_entry_t         kc_mem  [lteh_pkg::TABLE_ENTRIES];
  lteh_pkg::count_row_t         row_mem [lteh_pkg::TABLE_ENTRIES];

  logic                         busy_q;
  lteh_pkg::work_t              work_q;
  lteh_pkg::key_entry_t         kc_rd_q;
  lteh_pkg::count_row_t         row_rd_q;
  logic                         out_valid_q;
  lteh_pkg::result_t            out_data_q, out_data_d;

  logic                         done;
  logic                         row_wr;
  lteh_pkg::count_row_t         base_row, row_new;
  logic [lteh_pkg::COUNT_BITS-1:0] old_cnt, new_cnt;

  assign pop_o       = q_valid_i && !busy_q;
  assign done        = busy_q && (!out_valid_q || out_ready_i);
  assign row_wr      = done && !work_q.is_read && !work_q.full;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // counter update, a fresh slot starts from an all-zero row
  always_comb begin
    base_row = work_q.is_new ? '0 : row_rd_q;
    old_cnt  = base_row[work_q.group];
    new_cnt  = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
    row_new  = base_row;
    row_new[work_q.group] = new_cnt;
  end

  always_comb begin
    out_data_d       = '0;
    out_data_d.slot  = work_q.slot;
    out_data_d.group = work_q.group;
    if (work_q.full) begin
      out_data_d.full = 1'b1;
    end else if (work_q.is_read) begin
      if (work_q.valid) begin
        out_data_d.valid = 1'b1;
        out_data_d.key   = kc_rd_q.key;
        out_data_d.cls   = kc_rd_q.cls;
        if (work_q.group < lteh_pkg::GROUP_W'(lteh_pkg::NUM_GROUPS)) begin
          out_data_d.count = row_rd_q[work_q.group];
        end
      end
    end else begin
      out_data_d.valid  = 1'b1;
      out_data_d.is_new = work_q.is_new;
      out_data_d.key    = work_q.key;
      out_data_d.cls    = work_q.is_new ? work_q.cls : kc_rd_q.cls;
      out_data_d.count  = new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memory ports: registered read at pop, write when the item retires
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q   <= q_head_i;
      kc_rd_q  <= kc_mem[q_head_i.slot];
      row_rd_q <= row_mem[q_head_i.slot];
    end
    if (row_wr) begin
      row_mem[work_q.slot] <= row_new;
    end
    if (row_wr && work_q.is_new) begin
      kc_mem[work_q.slot] <= '{cls: work_q.cls, key: work_q.key};
    end
    if (done) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== rtl/loop_trip_estimate_histogram.sv =====
// an input beat passes the front capture register, the queue, the back's read register and
// the output register; the front holds one item for its key match and classification until it
// is pushed, and the back holds one item through the counter-row read-modify-write
// a 2-entry queue between front and back absorbs output stalls
// reset: rst_ni clears slot valid bits and the allocation count, a counter row starts at zero
// on allocation, so there is no clearing pass and items are taken as soon as reset is released
module loop_trip_estimate_histogram (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input beat: tdata = loop_key[63:0], trip_count[95:64], estimated_count[127:96],
  // loop_class[135:128], read_slot[141:136], read_group[144:142], zero fill
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lteh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser = mode[0]
  input  logic [0:0]                       s_axis_tuser,
  // result beat: tdata = slot[5:0], group[8:6], count[40:9], entry_key[104:41],
  // entry_class[112:105], is_new[113], table_full[114], entry_valid[115], zero fill
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lteh_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  // front to queue
  logic              push;
  lteh_pkg::work_t   push_data;
  logic              q_full;

  // queue to back
  logic              q_valid;
  lteh_pkg::work_t   q_head;
  logic              pop;

  lteh_pkg::result_t result;

  // front: captures a beat, matches the key against all slots in parallel,
  // sorts the estimate into its group and allocates new slots in order
  lteh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser[0]),
    .in_key_i    (s_axis_tdata[63:0]),
    .in_trip_i   (s_axis_tdata[95:64]),
    .in_est_i    (s_axis_tdata[127:96]),
    .in_class_i  (s_axis_tdata[135:128]),
    .in_rslot_i  (s_axis_tdata[141:136]),
    .in_rgroup_i (s_axis_tdata[144:142]),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  // short queue so the front keeps taking beats while a result waits
  lteh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // back: key/class and counter-row memories, saturating update, output register
  lteh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result)
  );

  // result fields packed from bit 0 up, zero fill to whole bytes
  assign m_axis_tdata = {{(lteh_pkg::M_TDATA_W - lteh_pkg::RESULT_W){1'b0}}, result};

endmodule

// ===== rtl/lteh_checker.sv =====
`include "loop_trip_estimate_histogram_assert.svh"

module lteh_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lteh_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // stalled result beat keeps its payload
  `LTEH_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result beat changed while stalled")

  // front is not ready in the cycle after it takes a beat
  `LTEH_ASSERT(a_in_spacing, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken on consecutive cycles")

  // a dropped key reports nothing from the table
  `LTEH_ASSERT_NEVER(a_full_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[114] && (m_axis_tdata[115] || m_axis_tdata[113] || (m_axis_tdata[40:9] != 32'd0) || (m_axis_tdata[5:0] != 6'd0)), "table full result carries slot data")

  // a freshly allocated slot counts exactly one
  `LTEH_ASSERT(a_new_first, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[113]) |-> (m_axis_tdata[115] && (m_axis_tdata[40:9] == 32'd1)), "new slot count is not one")

  // an empty slot reads as zero
  `LTEH_ASSERT(a_empty_zero, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tdata[115]) |-> ((m_axis_tdata[40:9] == 32'd0) && (m_axis_tdata[104:41] == 64'd0)), "empty slot returns data")

endmodule

bind loop_trip_estimate_histogram lteh_checker u_lteh_checker (.*);
